>>> rtl/sls_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_pkg
// Shared constants and types for the sample log sorter with statistics.
// ---------------------------------------------------------------------------
package sls_pkg;

   // Batch capacity and field widths
   localparam int MAX_SAMPLES = 32;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int VALUE_W     = 8;
   localparam int RANK_W      = 6;
   localparam int BELOW_W     = 7;
   localparam int SUM_W       = 14;

   localparam logic signed [VALUE_W-1:0] THRESH_RESET = 8'sd34;

   // Control sequencer states
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Contents of one sorting cell
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } cell_data_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                      insert;
      logic                      shift;
      logic signed [VALUE_W-1:0] sample;
   } cell_cmd_type;

endpackage : sls_pkg
`default_nettype wire

>>> rtl/sls_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_req_if
// Sample input channel: one sample per transaction, last marks batch end.
// ---------------------------------------------------------------------------
interface sls_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sls_pkg::VALUE_W-1:0] sample;
   logic                               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface : sls_req_if
`default_nettype wire

>>> rtl/sls_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_rsp_if
// Sorted result channel: one sorted value with batch statistics per
// transaction.
// ---------------------------------------------------------------------------
interface sls_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sls_pkg::VALUE_W-1:0] sorted_value;
   logic        [sls_pkg::RANK_W-1:0]  rank;
   logic                               final_res;
   logic        [sls_pkg::BELOW_W-1:0] below_count;
   logic signed [sls_pkg::SUM_W-1:0]   batch_sum;

   modport source (output valid, output sorted_value, output rank, output final_res,
                   output below_count, output batch_sum, input ready);
   modport sink   (input valid, input sorted_value, input rank, input final_res,
                   input below_count, input batch_sum, output ready);
endinterface : sls_rsp_if
`default_nettype wire

>>> rtl/sls_csr_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_csr_if
// Configuration write channel carrying the low threshold register.
// ---------------------------------------------------------------------------
interface sls_csr_if;
   logic                               valid;
   logic                               ready;
   logic signed [sls_pkg::VALUE_W-1:0] low_threshold;

   modport source (output valid, output low_threshold, input ready);
   modport sink   (input valid, input low_threshold, output ready);
endinterface : sls_csr_if
`default_nettype wire

>>> rtl/sls_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_cell
// One insertion sort cell: keeps, takes the new sample, takes its left
// neighbor on insert, or takes its right neighbor when the chain drains.
// ---------------------------------------------------------------------------
module sls_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sls_pkg::cell_cmd_type  cmd,
   input  wire logic                   prev_le,    // left neighbor <= sample
   input  wire sls_pkg::cell_data_type prev_data,
   input  wire sls_pkg::cell_data_type next_data,
   output      sls_pkg::cell_data_type data,
   output      logic                   gt          // empty or greater than sample
);

   logic                               valid_ff, valid_in;
   logic signed [sls_pkg::VALUE_W-1:0] value_ff, value_in;

   // Empty cells sit at the tail, so gt is monotonic along the chain
   assign gt   = !valid_ff || (value_ff > cmd.sample);
   assign data = '{valid: valid_ff, value: value_ff};

   // Next cell contents
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.insert) begin
         if (gt) begin
            if (prev_le) begin
               valid_in = 1'b1;
               value_in = cmd.sample;
            end else begin
               valid_in = prev_data.valid;
               value_in = prev_data.value;
            end
         end
      end else if (cmd.shift) begin
         valid_in = next_data.valid;
         value_in = next_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule : sls_cell
`default_nettype wire

>>> rtl/sample_log_sorter_with_stats.sv
`default_nettype none
// Loading: one sample transaction per cycle, each written into the cell chain as it is taken.
// Draining: after the last sample the sequencer enters ST_DRAIN and registers cell 0 into the
//   output register; then one result per cycle, paced by the output register and sink ready.
// Samples are not taken while a batch drains; the next batch may start once the final
//   result sits in the output register.
// Reset (synchronous) empties the chain, clears count/sum/below and sets threshold to 34.
// ---------------------------------------------------------------------------
// sample_log_sorter_with_stats
// Insertion sorter over a chain of cells with below-threshold count and batch sum.
// ---------------------------------------------------------------------------
module sample_log_sorter_with_stats (
   input wire logic clock,
   input wire logic reset,
   sls_req_if.sink   req_chan,
   sls_rsp_if.source rsp_chan,
   sls_csr_if.sink   csr_chan
);

   localparam int N = sls_pkg::MAX_SAMPLES;

   sls_pkg::state_type state_ff, state_in;

   logic signed [sls_pkg::VALUE_W-1:0] thresh_ff;
   logic        [sls_pkg::CNT_W-1:0]   count_ff, count_in;
   logic        [sls_pkg::CNT_W-1:0]   rank_ff, rank_in;
   logic        [sls_pkg::BELOW_W-1:0] below_ff, below_in;
   logic signed [sls_pkg::SUM_W-1:0]   sum_ff, sum_in;

   logic                               rsp_valid_ff;
   logic signed [sls_pkg::VALUE_W-1:0] rsp_value_ff;
   logic        [sls_pkg::RANK_W-1:0]  rsp_rank_ff;
   logic                               rsp_final_ff;
   logic        [sls_pkg::BELOW_W-1:0] rsp_below_ff;
   logic signed [sls_pkg::SUM_W-1:0]   rsp_sum_ff;

   logic req_ready, req_take, store_ok, emit, emit_final;

   sls_pkg::cell_cmd_type  cmd;
   sls_pkg::cell_data_type cell_data [N];
   logic                   cell_gt   [N];

   // Threshold register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= sls_pkg::THRESH_RESET;
      end else if (csr_chan.valid) begin
         thresh_ff <= csr_chan.low_threshold;
      end
   end

   // Handshake qualifiers
   assign req_ready      = (state_ff == sls_pkg::ST_LOAD);
   assign req_chan.ready = req_ready;
   assign req_take       = req_chan.valid && req_ready;
   assign store_ok       = (count_ff < sls_pkg::CNT_W'(N));
   assign emit_final     = (sls_pkg::CNT_W'(rank_ff + 1'b1) == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sls_pkg::ST_LOAD: begin
            if (req_take && req_chan.last) state_in = sls_pkg::ST_DRAIN;
         end
         sls_pkg::ST_DRAIN: begin
            if (emit && emit_final) state_in = sls_pkg::ST_LOAD;
         end
         default: state_in = sls_pkg::ST_LOAD;
      endcase
   end

   // State outputs
   always_comb begin
      emit = 1'b0;
      case (state_ff)
         sls_pkg::ST_LOAD:  emit = 1'b0;
         sls_pkg::ST_DRAIN: emit = !rsp_valid_ff || rsp_chan.ready;
         default:           emit = 1'b0;
      endcase
   end

   // Cell chain command
   assign cmd = '{insert: req_take && store_ok, shift: emit, sample: req_chan.sample};

   // Sorting chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      sls_pkg::cell_data_type prev_d, next_d;
      logic                   prev_le;

      if (i == 0) begin : g_head
         assign prev_le = 1'b1;
         assign prev_d  = '0;
      end else begin : g_body
         assign prev_le = !cell_gt[i-1];
         assign prev_d  = cell_data[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_link
         assign next_d = cell_data[i+1];
      end

      sls_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_le   (prev_le),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (cell_data[i]),
         .gt        (cell_gt[i])
      );
   end

   // Batch statistics and rank counter
   always_comb begin
      count_in = count_ff;
      below_in = below_ff;
      sum_in   = sum_ff;
      rank_in  = rank_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + sls_pkg::SUM_W'(req_chan.sample);
         if (req_chan.sample < thresh_ff) below_in = below_ff + 1'b1;
      end
      if (emit) begin
         if (emit_final) begin
            count_in = '0;
            below_in = '0;
            sum_in   = '0;
            rank_in  = '0;
         end else begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sls_pkg::ST_LOAD;
         count_ff <= '0;
         below_ff <= '0;
         sum_ff   <= '0;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         below_ff <= below_in;
         sum_ff   <= sum_in;
         rank_ff  <= rank_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_value_ff <= cell_data[0].value;
         rsp_rank_ff  <= sls_pkg::RANK_W'(rank_ff);
         rsp_final_ff <= emit_final;
         rsp_below_ff <= below_ff;
         rsp_sum_ff   <= sum_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.rank         = rsp_rank_ff;
   assign rsp_chan.final_res    = rsp_final_ff;
   assign rsp_chan.below_count  = rsp_below_ff;
   assign rsp_chan.batch_sum    = rsp_sum_ff;

endmodule : sample_log_sorter_with_stats
`default_nettype wire
